// ----- rtl/core/gmc_pkg.sv -----
// Shared types, constants and a helper function of the gate motor controller.
`default_nettype none
package gmc_pkg;

    localparam int COUNT_WIDTH = 17;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int STATE_W     = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] MOVE_TIMEOUT_RESET = CFG_W'(2000);
    localparam logic [CFG_W-1:0] OPEN_WAIT_RESET    = CFG_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WAIT    = CFG_IDX_W'(1);

    localparam logic [STATE_W-1:0] GS_INIT    = 3'd0;
    localparam logic [STATE_W-1:0] GS_CALIB   = 3'd1;
    localparam logic [STATE_W-1:0] GS_CLOSING = 3'd2;
    localparam logic [STATE_W-1:0] GS_OPENING = 3'd3;
    localparam logic [STATE_W-1:0] GS_CLOSED  = 3'd4;
    localparam logic [STATE_W-1:0] GS_OPEN    = 3'd5;
    localparam logic [STATE_W-1:0] GS_WAIT    = 3'd6;
    localparam logic [STATE_W-1:0] GS_FAULT   = 3'd7;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [CFG_W-1:0]       t_cfg;

    typedef enum logic [7:0] {
        S_INIT    = 8'b0000_0001,
        S_CALIB   = 8'b0000_0010,
        S_CLOSING = 8'b0000_0100,
        S_OPENING = 8'b0000_1000,
        S_CLOSED  = 8'b0001_0000,
        S_OPEN    = 8'b0010_0000,
        S_WAIT    = 8'b0100_0000,
        S_FAULT   = 8'b1000_0000
    } t_state;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [STATE_W-1:0] state_code(input t_state st);
        logic [STATE_W-1:0] code;
        case (st)
            S_INIT:    code = GS_INIT;
            S_CALIB:   code = GS_CALIB;
            S_CLOSING: code = GS_CLOSING;
            S_OPENING: code = GS_OPENING;
            S_CLOSED:  code = GS_CLOSED;
            S_OPEN:    code = GS_OPEN;
            S_WAIT:    code = GS_WAIT;
            default:   code = GS_FAULT;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gmc_tick_if.sv -----
// Input channel carrying one sampled control tick word.
`default_nettype none
interface gmc_tick_if;
    logic valid;
    logic ready;
    logic open_limit;
    logic closed_limit;
    logic reset_button;

    modport source (output valid, output open_limit, output closed_limit,
                    output reset_button, input ready);
    modport sink (input valid, input open_limit, input closed_limit,
                  input reset_button, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gmc_drive_if.sv -----
// Output channel carrying one drive and state word per tick.
`default_nettype none
interface gmc_drive_if;
    logic       valid;
    logic       ready;
    logic       motor_close;
    logic       motor_open;
    logic       lamp_on;
    logic       buzz_on;
    logic [2:0] gate_state;

    modport source (output valid, output motor_close, output motor_open,
                    output lamp_on, output buzz_on, output gate_state, input ready);
    modport sink (input valid, input motor_close, input motor_open,
                  input lamp_on, input buzz_on, input gate_state, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gate_motor_controller_fsm_top.sv -----
// Gate motor controller top level: tick register, state machine and drive register.
//
// Each word on i_tick is one control tick with the sampled open limit, closed
// limit and reset button. For every tick the block returns exactly one word on
// o_drive: the motor, lamp and buzzer drives of the state executed on that tick
// and the new state code.
// A tick is captured in an input register; when the output register is free or
// being taken, the state machine and tick counter update and the drive word is
// loaded into the output register. One tick is accepted every cycle while
// o_drive.ready stays high.
// When the receiver stalls, the drive word holds in the output register, one
// more tick may wait in the input register, and i_tick.ready then drops until
// the drive word is taken.
// The timeout registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them only while the block is idle, as the block leaves this to the user.
// A synchronous active-low reset returns the machine to init, clears the
// timer and pending fault, restores the timeout registers to 2000 and 500
// ticks, and empties both registers of the pipeline.
`default_nettype none
module gate_motor_controller_fsm_top
    import gmc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_W-1:0]     i_cfg_data,
    gmc_tick_if.sink            i_tick,
    gmc_drive_if.source         o_drive
);

    t_cfg   r_move_timeout;
    t_cfg   r_open_wait;

    logic   r_in_valid;
    logic   r_in_open;
    logic   r_in_closed;
    logic   r_in_button;

    t_state r_state;
    t_state n_state;
    t_count r_cnt;
    t_count n_cnt;
    logic   r_run;
    logic   n_run;
    logic   r_fp;
    logic   n_fp;
    logic   r_fg;
    logic   n_fg;

    logic   r_out_valid;
    logic   r_out_mc;
    logic   r_out_mo;
    logic   r_out_lamp;
    logic   r_out_buzz;
    logic [STATE_W-1:0] r_out_state;

    logic   n_mc;
    logic   n_mo;
    logic   n_lamp;
    logic   n_buzz;

    logic   advance;
    t_count tick_cnt;
    logic   move_over;
    logic   wait_over;

    assign advance      = r_in_valid && (!r_out_valid || o_drive.ready);
    assign i_tick.ready = !r_in_valid || advance;

    assign tick_cnt  = r_run ? ((r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1) : '0;
    assign move_over = CMP_W'(tick_cnt) > CMP_W'(r_move_timeout);
    assign wait_over = CMP_W'(tick_cnt) > CMP_W'(r_open_wait);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_timeout <= MOVE_TIMEOUT_RESET;
            r_open_wait    <= OPEN_WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOVE_TIMEOUT: r_move_timeout <= i_cfg_data;
                CFG_OPEN_WAIT:    r_open_wait    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_run   = r_run;
        n_fp    = r_fp;
        n_fg    = r_fg;
        n_mc    = 1'b0;
        n_mo    = 1'b0;
        n_lamp  = 1'b0;
        n_buzz  = 1'b0;
        case (r_state)
            S_INIT: begin
                n_cnt   = '0;
                n_run   = 1'b0;
                n_fp    = 1'b0;
                n_fg    = 1'b0;
                n_state = S_CALIB;
            end
            S_CALIB: begin
                n_mc   = 1'b1;
                n_buzz = 1'b1;
                n_cnt  = tick_cnt;
                n_run  = 1'b1;
                if (r_in_closed) begin
                    n_cnt   = '0;
                    n_run   = 1'b0;
                    n_state = S_CLOSED;
                end else if (move_over) begin
                    n_cnt   = '0;
                    n_run   = 1'b0;
                    n_fp    = 1'b0;
                    n_state = S_FAULT;
                end
            end
            S_CLOSING: begin
                n_mc   = 1'b1;
                n_buzz = 1'b1;
                n_cnt  = tick_cnt;
                n_run  = 1'b1;
                if (r_in_closed) begin
                    n_cnt = '0;
                    n_run = 1'b0;
                    if (r_fp && !r_fg) begin
                        n_fp    = 1'b0;
                        n_state = S_FAULT;
                    end else begin
                        n_state = S_CLOSED;
                    end
                end else if (move_over) begin
                    n_cnt   = '0;
                    n_run   = 1'b0;
                    n_fp    = 1'b1;
                    n_fg    = 1'b1;
                    n_state = S_OPENING;
                end
            end
            S_OPENING: begin
                n_mo   = 1'b1;
                n_lamp = 1'b1;
                n_buzz = 1'b1;
                n_cnt  = tick_cnt;
                n_run  = 1'b1;
                if (r_in_open) begin
                    n_cnt = '0;
                    n_run = 1'b0;
                    if (r_fp && r_fg) begin
                        n_fp    = 1'b0;
                        n_state = S_FAULT;
                    end else begin
                        n_state = S_OPEN;
                    end
                end else if (move_over) begin
                    n_cnt   = '0;
                    n_run   = 1'b0;
                    n_fp    = 1'b1;
                    n_fg    = 1'b0;
                    n_state = S_CLOSING;
                end
            end
            S_CLOSED: begin
                n_state = S_OPENING;
            end
            S_OPEN: begin
                n_cnt   = '0;
                n_run   = 1'b0;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_cnt = tick_cnt;
                n_run = 1'b1;
                if (wait_over) begin
                    n_cnt   = '0;
                    n_run   = 1'b0;
                    n_state = S_CLOSING;
                end
            end
            default: begin
                if (r_in_button) begin
                    n_state = S_INIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_in_open   <= i_tick.open_limit;
            r_in_closed <= i_tick.closed_limit;
            r_in_button <= i_tick.reset_button;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_run   <= 1'b0;
            r_fp    <= 1'b0;
            r_fg    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_fp    <= n_fp;
            r_fg    <= n_fg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_drive.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mc    <= n_mc;
            r_out_mo    <= n_mo;
            r_out_lamp  <= n_lamp;
            r_out_buzz  <= n_buzz;
            r_out_state <= state_code(n_state);
        end
    end

    assign o_drive.valid       = r_out_valid;
    assign o_drive.motor_close = r_out_mc;
    assign o_drive.motor_open  = r_out_mo;
    assign o_drive.lamp_on     = r_out_lamp;
    assign o_drive.buzz_on     = r_out_buzz;
    assign o_drive.gate_state  = r_out_state;

    a_motor_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drive.valid |-> !(o_drive.motor_open && o_drive.motor_close))
        else $error("motor driven in both directions");

    a_timer_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_cnt == '0))
        else $error("tick count nonzero while timer idle");

    a_fault_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_state == S_FAULT) && !r_in_button) |=> (r_state == S_FAULT))
        else $error("fault state left without reset button");

    a_stall_holds_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("stalled tick lost from input register");

endmodule
`default_nettype wire
